@@ sv/bfx_pkg.sv @@
// ----------------------------------------------------------------------------
// bfx_pkg
// Shared types and constants for the Brainfuck program executor.
// ----------------------------------------------------------------------------
package bfx_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_OUTPUT  = 3'd2,
    ST_HALTED  = 3'd3,
    ST_BUDGET  = 3'd4,
    ST_BRACKET = 3'd5,
    ST_NOPROG  = 3'd6
  } status_e;

  // Request types.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_RESUME = 1'b1;

  // Command characters.
  localparam logic [7:0] CH_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] CH_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] CH_INC   = 8'h2B;  // '+'
  localparam logic [7:0] CH_DEC   = 8'h2D;  // '-'
  localparam logic [7:0] CH_OUT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'

  localparam int unsigned BudgetW     = 21;
  localparam logic [BudgetW-1:0] BudgetReset = 21'd65536;

  typedef struct packed {
    logic       req_type;
    logic [7:0] program_char;
    logic       last_char;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] out_byte;
  } res_t;

endpackage

@@ sv/bfx_ram.sv @@
// ----------------------------------------------------------------------------
// bfx_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/bf_program_executor.sv @@
// ----------------------------------------------------------------------------
// bf_program_executor
// Loads a Brainfuck program and runs it on a byte tape, one step at a time.
// ----------------------------------------------------------------------------
// A load result waits in S_DONE until the output register is free; the
// block then returns to S_IDLE, or first clears the tape. A resume runs
// each instruction through S_FETCH and S_EXEC, and a bracket scan visits
// each character in a read and a check state, as the program and tape RAM
// reads are registered. After reset, halt, bracket error or reload, a pass
// clearing all TAPE_CELLS tape cells runs, one cell per cycle, and no input
// is accepted. Configuration writes are taken in every cycle.
module bf_program_executor #(
  parameter int unsigned TAPE_CELLS    = 2048,
  parameter int unsigned PROGRAM_DEPTH = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bfx_pkg::req_t        in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bfx_pkg::res_t        out_data_o,
  input  logic                 cfg_we_i,
  input  logic [20:0]          cfg_data_i
);
  import bfx_pkg::*;

  localparam int unsigned TW = $clog2(TAPE_CELLS);
  localparam int unsigned AW = $clog2(PROGRAM_DEPTH);
  localparam int unsigned LW = $clog2(PROGRAM_DEPTH + 1);
  localparam logic [TW-1:0] CpHome = TW'(TAPE_CELLS / 2);
  localparam logic [TW-1:0] CpLast = TW'(TAPE_CELLS - 1);
  localparam logic [LW-1:0] LenMax = LW'(PROGRAM_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_EXEC,
    S_FWD_RD, S_FWD_CHK, S_BWD_RD, S_BWD_CHK, S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [LW-1:0]        len_q, len_d;
  logic                 ready_q, ready_d;
  logic [LW-1:0]        ip_q, ip_d;
  logic [TW-1:0]        cp_q, cp_d;
  logic [TW-1:0]        clr_q, clr_d;
  logic [LW-1:0]        scan_q, scan_d;
  logic [LW-1:0]        depth_q, depth_d;
  logic [BudgetW-1:0]   steps_q, steps_d;
  logic [BudgetW-1:0]   budget_q;
  logic                 clr_pend_q, clr_pend_d;
  res_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  res_t                 out_q, out_d;

  logic                 prog_we;
  logic [AW-1:0]        prog_waddr, prog_raddr;
  logic [7:0]           prog_rdata;
  logic                 tape_we;
  logic [TW-1:0]        tape_waddr;
  logic [7:0]           tape_wdata, tape_rdata;
  logic [BudgetW-1:0]   budget_eff;

  assign budget_eff  = (budget_q == '0) ? BudgetW'(1) : budget_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Program store and tape.
  bfx_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (prog_waddr),
    .wdata_i (in_data_i.program_char),
    .raddr_i (prog_raddr),
    .rdata_o (prog_rdata)
  );

  bfx_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (cp_q),
    .rdata_o (tape_rdata)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    ready_d     = ready_q;
    ip_d        = ip_q;
    cp_d        = cp_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    depth_d     = depth_q;
    steps_d     = steps_q;
    clr_pend_d  = clr_pend_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    prog_we     = 1'b0;
    prog_waddr  = len_q[AW-1:0];
    prog_raddr  = ip_q[AW-1:0];
    tape_we     = 1'b0;
    tape_waddr  = cp_q;
    tape_wdata  = tape_rdata;

    case (state_q)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_q;
        tape_wdata = 8'h00;
        clr_d      = clr_q + TW'(1);
        if (clr_q == CpLast) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          res_d.out_byte = 8'h00;
          clr_pend_d     = 1'b0;
          state_d        = S_DONE;
          if (in_data_i.req_type == REQ_LOAD) begin
            if (ready_q) begin
              // Reload abandons the old run and starts a new program.
              prog_we    = 1'b1;
              prog_waddr = '0;
              len_d      = LW'(1);
              ip_d       = '0;
              cp_d       = CpHome;
              clr_d      = '0;
              clr_pend_d = 1'b1;
              res_d.status = ST_LOADED;
            end else if (len_q < LenMax) begin
              prog_we      = 1'b1;
              len_d        = len_q + LW'(1);
              res_d.status = ST_LOADED;
            end else begin
              res_d.status = ST_FULL;
            end
            ready_d = in_data_i.last_char;
          end else if (!ready_q) begin
            res_d.status = ST_NOPROG;
          end else begin
            steps_d = '0;
            state_d = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        if (ip_q >= len_q) begin
          res_d.status = ST_HALTED;
          len_d        = '0;
          ready_d      = 1'b0;
          ip_d         = '0;
          cp_d         = CpHome;
          clr_d        = '0;
          clr_pend_d   = 1'b1;
          state_d      = S_DONE;
        end else if (steps_q >= budget_eff) begin
          res_d.status = ST_BUDGET;
          state_d      = S_DONE;
        end else begin
          steps_d = steps_q + BudgetW'(1);
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_FETCH;
        ip_d    = ip_q + LW'(1);
        case (prog_rdata)
          CH_RIGHT: cp_d = (cp_q == CpLast) ? '0 : cp_q + TW'(1);
          CH_LEFT:  cp_d = (cp_q == '0) ? CpLast : cp_q - TW'(1);
          CH_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 8'd1;
          end
          CH_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 8'd1;
          end
          CH_OUT: begin
            res_d.status   = ST_OUTPUT;
            res_d.out_byte = tape_rdata;
            state_d        = S_DONE;
          end
          CH_OPEN: begin
            if (tape_rdata == 8'h00) begin
              scan_d  = ip_q + LW'(1);
              depth_d = LW'(1);
              state_d = S_FWD_RD;
            end
          end
          CH_CLOSE: begin
            if (tape_rdata != 8'h00) begin
              scan_d  = ip_q;
              depth_d = LW'(1);
              state_d = S_BWD_RD;
            end
          end
          default: ;
        endcase
      end

      // Forward scan for the matching closing bracket.
      S_FWD_RD: begin
        prog_raddr = scan_q[AW-1:0];
        if (scan_q >= len_q) begin
          state_d = S_FWD_CHK;
          res_d.status = ST_BRACKET;
          len_d        = '0;
          ready_d      = 1'b0;
          ip_d         = '0;
          cp_d         = CpHome;
          clr_d        = '0;
          clr_pend_d   = 1'b1;
          state_d      = S_DONE;
        end else begin
          state_d = S_FWD_CHK;
        end
      end

      S_FWD_CHK: begin
        state_d = S_FWD_RD;
        scan_d  = scan_q + LW'(1);
        if (prog_rdata == CH_OPEN) begin
          depth_d = depth_q + LW'(1);
        end else if (prog_rdata == CH_CLOSE) begin
          depth_d = depth_q - LW'(1);
          if (depth_q == LW'(1)) begin
            ip_d    = scan_q + LW'(1);
            state_d = S_FETCH;
          end
        end
      end

      // Backward scan for the matching opening bracket.
      S_BWD_RD: begin
        prog_raddr = scan_q[AW-1:0] - AW'(1);
        if (scan_q == '0) begin
          res_d.status = ST_BRACKET;
          len_d        = '0;
          ready_d      = 1'b0;
          ip_d         = '0;
          cp_d         = CpHome;
          clr_d        = '0;
          clr_pend_d   = 1'b1;
          state_d      = S_DONE;
        end else begin
          scan_d  = scan_q - LW'(1);
          state_d = S_BWD_CHK;
        end
      end

      S_BWD_CHK: begin
        state_d = S_BWD_RD;
        if (prog_rdata == CH_CLOSE) begin
          depth_d = depth_q + LW'(1);
        end else if (prog_rdata == CH_OPEN) begin
          depth_d = depth_q - LW'(1);
          if (depth_q == LW'(1)) begin
            ip_d    = scan_q + LW'(1);
            state_d = S_FETCH;
          end
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = clr_pend_q ? S_CLEAR : S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control and budget registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      len_q       <= '0;
      ready_q     <= 1'b0;
      ip_q        <= '0;
      cp_q        <= CpHome;
      clr_q       <= '0;
      scan_q      <= '0;
      depth_q     <= '0;
      steps_q     <= '0;
      clr_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      budget_q    <= BudgetReset;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ready_q     <= ready_d;
      ip_q        <= ip_d;
      cp_q        <= cp_d;
      clr_q       <= clr_d;
      scan_q      <= scan_d;
      depth_q     <= depth_d;
      steps_q     <= steps_d;
      clr_pend_q  <= clr_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        budget_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bf_program_executor. A directed table covers most
// status codes, byte wrap, pointer wrap, reloads and bracket errors. Random
// programs then run under several step budgets. A predictor in the bench
// supplies the expected results, apart from directed rows with fixed ones.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfx_pkg::*;

  localparam int unsigned TapeCells  = 2048;
  localparam int unsigned ProgDepth  = 4096;
  localparam int unsigned StallLimit = 200000;

  typedef struct {
    req_t d;
    bit   fixed;
    res_t r;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  res_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [20:0] cfg_data_i = '0;

  // Predictor state.
  logic [7:0]  prog_mem [ProgDepth];
  logic [12:0] prog_len = '0;
  bit          prog_ready = 1'b0;
  logic [12:0] ip = '0;
  logic [7:0]  tape_mem [TapeCells];
  logic [10:0] cp = 11'(TapeCells / 2);
  logic [20:0] budget = BudgetReset;

  res_t pending_q[$];
  int   errors = 0;
  bit   no_idle = 1'b0;
  bit   hold_req = 1'b0;
  int   quiet_cycles = 0;

  bf_program_executor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Returns the machine to its state after a halt.
  function automatic void wipe_machine();
    foreach (tape_mem[i]) tape_mem[i] = '0;
    prog_len   = '0;
    prog_ready = 1'b0;
    ip         = '0;
    cp         = 11'(TapeCells / 2);
  endfunction

  // Computes the result of one transaction and advances the predictor.
  function automatic res_t run_request(req_t d);
    res_t        r;
    int unsigned lim, steps, depth, j;
    logic [7:0]  c;
    bit          done, fail, found;
    r.out_byte = '0;
    r.status   = ST_LOADED;
    if (d.req_type == REQ_LOAD) begin
      if (prog_ready) wipe_machine();
      if (prog_len < ProgDepth) begin
        prog_mem[prog_len[11:0]] = d.program_char;
        prog_len++;
        r.status = ST_LOADED;
      end else begin
        r.status = ST_FULL;
      end
      if (d.last_char) prog_ready = 1'b1;
    end else if (!prog_ready) begin
      r.status = ST_NOPROG;
    end else begin
      lim   = (budget == 0) ? 1 : budget;
      steps = 0;
      done  = 1'b0;
      while (!done) begin
        fail = 1'b0;
        if (ip >= prog_len) begin
          wipe_machine();
          r.status = ST_HALTED;
          done = 1'b1;
        end else if (steps >= lim) begin
          r.status = ST_BUDGET;
          done = 1'b1;
        end else begin
          steps++;
          c = prog_mem[ip[11:0]];
          case (c)
            CH_RIGHT: cp = cp + 1'b1;
            CH_LEFT:  cp = cp - 1'b1;
            CH_INC:   tape_mem[cp] = tape_mem[cp] + 1'b1;
            CH_DEC:   tape_mem[cp] = tape_mem[cp] - 1'b1;
            CH_OUT: begin
              r.out_byte = tape_mem[cp];
              r.status = ST_OUTPUT;
              done = 1'b1;
            end
            CH_OPEN: begin
              if (tape_mem[cp] == 0) begin
                // Scan forward for the matching close bracket.
                depth = 1;
                found = 1'b0;
                for (j = ip + 1; j < prog_len && !found; j++) begin
                  if (prog_mem[12'(j)] == CH_OPEN) depth++;
                  else if (prog_mem[12'(j)] == CH_CLOSE) begin
                    depth--;
                    if (depth == 0) begin
                      found = 1'b1;
                      ip = 13'(j);
                    end
                  end
                end
                fail = !found;
              end
            end
            CH_CLOSE: begin
              if (tape_mem[cp] != 0) begin
                // Scan backward for the matching open bracket.
                depth = 1;
                found = 1'b0;
                j = ip;
                while (j > 0 && !found) begin
                  j--;
                  if (prog_mem[12'(j)] == CH_CLOSE) depth++;
                  else if (prog_mem[12'(j)] == CH_OPEN) begin
                    depth--;
                    if (depth == 0) begin
                      found = 1'b1;
                      ip = 13'(j);
                    end
                  end
                end
                fail = !found;
              end
            end
            default: ;
          endcase
          if (fail) begin
            wipe_machine();
            r.status = ST_BRACKET;
            done = 1'b1;
          end else begin
            ip++;
          end
        end
      end
    end
    return r;
  endfunction

  // Drives one input transaction and waits for it to be accepted.
  task automatic drive_request(req_t d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Predicts, queues the expectation, then sends the transaction.
  task automatic issue(req_t d, output res_t r);
    r = run_request(d);
    pending_q.push_back(r);
    drive_request(d);
  endtask

  // Stops offering input and waits for every expected result.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_budget(logic [20:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    budget = v;
  endtask

  function automatic row_t mk(logic rq, logic [7:0] ch, logic last, bit fx, status_e st,
                              logic [7:0] ob);
    row_t w;
    w.d.req_type     = rq;
    w.d.program_char = ch;
    w.d.last_char    = last;
    w.fixed          = fx;
    w.r.status       = st;
    w.r.out_byte     = ob;
    return w;
  endfunction

  function automatic logic [7:0] pick_char(bit safe);
    logic [7:0] set [7] = '{CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OUT, CH_OPEN, CH_CLOSE};
    int k;
    k = $urandom_range(0, 9);
    if (k >= 7) return 8'($urandom_range(0, 255));
    if (safe && (set[k] == CH_OPEN || set[k] == CH_CLOSE)) return CH_INC;
    return set[k];
  endfunction

  // Builds one random program. Safe programs always terminate: a lone close
  // bracket is only placed before any loop, so it can never jump back.
  function automatic void build_program(bit safe, ref logic [7:0] prog[$]);
    int n, depth;
    bit broken;
    bit opened;
    logic [7:0] c;
    prog.delete();
    n = $urandom_range(1, 10);
    broken = ($urandom_range(0, 4) == 0);
    depth = 0;
    opened = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (safe) begin
        case ($urandom_range(0, 9))
          0: begin
            prog.push_back(CH_OPEN);
            prog.push_back(CH_DEC);
            prog.push_back(CH_CLOSE);
            opened = 1'b1;
          end
          1: prog.push_back((!opened && $urandom_range(0, 3) == 0) ? CH_CLOSE : CH_OUT);
          default: prog.push_back(pick_char(1'b1));
        endcase
      end else begin
        c = pick_char(1'b0);
        if (c == CH_OPEN) depth++;
        if (c == CH_CLOSE) begin
          if (depth == 0 && !broken) c = CH_INC;
          else if (depth > 0) depth--;
        end
        prog.push_back(c);
      end
    end
    if (!broken) repeat (depth) prog.push_back(CH_CLOSE);
  endfunction

  // Receiver with random stalls and one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_data_o.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.out_byte !== e.out_byte) begin
          $error("out_byte: expected %0d, actual %0d", e.out_byte, out_data_o.out_byte);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    row_t        rows[$];
    res_t        r;
    req_t        d;
    logic [7:0]  prog[$];
    logic [20:0] budgets [8] = '{21'd1, 21'd0, 21'd7, 21'd50, 21'd1048575, 21'd1048576,
                                 21'd300, 21'd2};
    int          phase_items, resumes;
    bit          safe;

    foreach (tape_mem[i]) tape_mem[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: status codes, wrap cases, reload and bracket errors.
    rows.push_back(mk(REQ_RESUME, 8'h00, 1'b0, 1'b1, ST_NOPROG, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_INC, 1'b0, 1'b1, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_INC, 1'b0, 1'b1, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_DEC, 1'b0, 1'b1, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, 8'hFF, 1'b0, 1'b1, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, 8'h00, 1'b0, 1'b1, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_OUT, 1'b1, 1'b1, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_RESUME, 8'hFF, 1'b1, 1'b1, ST_OUTPUT, 8'd1));
    rows.push_back(mk(REQ_RESUME, 8'h00, 1'b0, 1'b1, ST_HALTED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_DEC, 1'b0, 1'b1, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_OUT, 1'b1, 1'b1, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_RESUME, 8'h00, 1'b0, 1'b1, ST_OUTPUT, 8'hFF));
    // Loading over a ready program starts a new one.
    rows.push_back(mk(REQ_LOAD, CH_INC, 1'b0, 1'b1, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_CLOSE, 1'b1, 1'b1, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_RESUME, 8'h00, 1'b0, 1'b1, ST_BRACKET, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_OPEN, 1'b1, 1'b1, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_RESUME, 8'h00, 1'b0, 1'b1, ST_BRACKET, 8'd0));
    // Walk left around the whole tape back to the marked home cell.
    rows.push_back(mk(REQ_LOAD, CH_DEC, 1'b0, 1'b0, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_LEFT, 1'b0, 1'b0, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_INC, 1'b0, 1'b0, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_OPEN, 1'b0, 1'b0, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_DEC, 1'b0, 1'b0, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_LEFT, 1'b0, 1'b0, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_INC, 1'b0, 1'b0, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_CLOSE, 1'b0, 1'b0, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_LOAD, CH_OUT, 1'b1, 1'b0, ST_LOADED, 8'd0));
    rows.push_back(mk(REQ_RESUME, 8'h00, 1'b0, 1'b0, ST_LOADED, 8'd0));
    foreach (rows[i]) begin
      r = run_request(rows[i].d);
      pending_q.push_back(rows[i].fixed ? rows[i].r : r);
      drive_request(rows[i].d);
    end

    // Random programs under a range of step budgets.
    foreach (budgets[ph]) begin
      write_budget(budgets[ph]);
      safe = (budgets[ph] > 1000);
      no_idle = (ph % 3 == 1);
      if (ph == 2) hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < 66) begin
        build_program(safe, prog);
        if ($urandom_range(0, 9) == 0) begin
          issue('{req_type: REQ_RESUME, program_char: 8'($urandom_range(0, 255)),
                  last_char: 1'($urandom_range(0, 1))}, r);
          phase_items++;
        end
        foreach (prog[i]) begin
          d.req_type     = REQ_LOAD;
          d.program_char = prog[i];
          d.last_char    = (i == prog.size() - 1);
          issue(d, r);
          phase_items++;
          if (!d.last_char && $urandom_range(0, 19) == 0) begin
            issue('{req_type: REQ_RESUME, program_char: 8'hA5, last_char: 1'b1}, r);
            phase_items++;
          end
        end
        resumes = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 6;
        for (int k = 0; k < resumes; k++) begin
          d.req_type     = REQ_RESUME;
          d.program_char = 8'($urandom_range(0, 255));
          d.last_char    = 1'($urandom_range(0, 1));
          issue(d, r);
          phase_items++;
          if (r.status == ST_HALTED || r.status == ST_BRACKET) break;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
